// ===== design/ffha_pkg.sv =====
package ffha_pkg;
    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int ALIGN_BYTES_DEF = 16;
    localparam int HDR_BYTES       = 8;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam int REG_BASE  = 0;
    localparam int REG_LIMIT = 1;
endpackage

// ===== design/ffha_ram.sv =====
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator with boundary tags. Commands on the s_ stream: allocate (0),
// free (1) and usable-size query (2); each beat gives exactly one m_ beat. Chunk sizes,
// used bits and free-list links live in four single-port-read RAMs (one entry per
// granule) with a registered read, driven by a small sequencer that does one
// RAM access step per cycle. Allocate walks the whole free list, then sizes, splits
// and updates the list. One item is in work at a time; a new beat is taken only
// once the previous result beat has been taken. No clearing pass after reset.
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES  = ffha_pkg::HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES = ffha_pkg::ALIGN_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [18:2] request_bytes, [50:19] payload_address, zero fill to 56
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] result_address, [48:32] usable_bytes, zero fill to 56
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import ffha_pkg::*;

    localparam int GRAN  = HEAP_BYTES / ALIGN_BYTES;
    localparam int AW    = $clog2(GRAN);
    localparam int GW    = AW + 1;          // granule count or NIL
    localparam int TW    = GW + 1;          // size + used bit
    localparam int SH    = $clog2(ALIGN_BYTES);
    localparam int LW    = $clog2(HEAP_BYTES) + 1;
    localparam int MINCH = 2 * HDR_BYTES + ALIGN_BYTES;
    localparam int MING  = (MINCH + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam logic [GW-1:0] NIL = GW'(GRAN);

    localparam logic [4:0] S_IDLE  = 5'd0,  S_DEC   = 5'd1,  S_WREQ  = 5'd2,
                           S_WCHK  = 5'd3,  S_APICK = 5'd4,  S_ARD   = 5'd5,
                           S_ARM   = 5'd6,  S_ASPL  = 5'd8,
                           S_ASPL2 = 5'd9,  S_APUSH = 5'd10, S_FHDR  = 5'd11,
                           S_FCHK  = 5'd12, S_FRGT  = 5'd13,
                           S_FLFT  = 5'd15, S_FLFT2 = 5'd16, S_FRMW  = 5'd17,
                           S_FRM2  = 5'd18, S_FEND  = 5'd19, S_QHDR  = 5'd20,
                           S_QOUT  = 5'd21, S_DONE  = 5'd22, S_RMGO  = 5'd23,
                           S_FLRD  = 5'd24;

    // RAM ports
    logic           hd_we, ft_we, nx_we, pv_we;
    logic [AW-1:0]  hd_wa, ft_wa, nx_wa, pv_wa, hd_ra, ft_ra, nx_ra, pv_ra;
    logic [TW-1:0]  hd_wd, ft_wd, hd_rd, ft_rd;
    logic [GW-1:0]  nx_wd, pv_wd, nx_rd, pv_rd;

    ffha_ram #(.WIDTH(TW), .DEPTH(GRAN)) u_hdr (.aclk, .we(hd_we), .waddr(hd_wa),
        .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
    ffha_ram #(.WIDTH(TW), .DEPTH(GRAN)) u_ftr (.aclk, .we(ft_we), .waddr(ft_wa),
        .wdata(ft_wd), .raddr(ft_ra), .rdata(ft_rd));
    ffha_ram #(.WIDTH(GW), .DEPTH(GRAN)) u_nxt (.aclk, .we(nx_we), .waddr(nx_wa),
        .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    ffha_ram #(.WIDTH(GW), .DEPTH(GRAN)) u_prv (.aclk, .we(pv_we), .waddr(pv_wa),
        .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));

    logic [4:0]    state_reg, state_next, ret_reg, ret_next;
    logic [31:0]   base_reg;
    logic [16:0]   limit_reg;
    logic [GW-1:0] head_reg, head_next, top_reg, top_next;
    logic [1:0]    cmd_reg;
    logic [16:0]   req_reg;
    logic [31:0]   addr_reg;
    logic [GW-1:0] need_reg, need_next, cur_reg, cur_next, best_reg, best_next;
    logic [GW-1:0] g_reg, g_next, sz_reg, sz_next, rm_reg, rm_next;
    logic [GW-1:0] steps_reg, steps_next;
    logic          ok_reg, ok_next;
    logic          m_valid_reg;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [16:0]   res_use_reg, res_use_next;

    // rounded base, chunk lookup
    logic [31:0] base_al, off;
    logic [GW-1:0] cap;
    assign base_al = {base_reg[31:SH], SH'(0)};
    assign off     = addr_reg - base_al - 32'(HDR_BYTES);
    assign cap     = (limit_reg > 17'(HEAP_BYTES)) ? GW'(GRAN) : GW'(limit_reg >> SH);

    logic [31:0] pay_best;
    assign pay_best = base_al + (32'(best_reg) << SH) + 32'(HDR_BYTES);

    // ALLOC need: ceil((n+16)/ALIGN), at least MING
    logic [17:0] nreq;
    logic [GW:0] need_raw;
    assign nreq     = (req_reg == 17'd0) ? 18'd1 : 18'(req_reg);
    assign need_raw = (GW+1)'((nreq + 18'(2 * HDR_BYTES + ALIGN_BYTES - 1)) >> SH);

    logic [GW-1:0] hsz;
    assign hsz = hd_rd[TW-1:1];

    assign s_tready  = (state_reg == S_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, res_use_reg, res_addr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NIL;
            top_reg     <= '0;
            base_reg    <= '0;
            limit_reg   <= 17'd65536;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            top_reg   <= top_next;
            if (cfg_valid && cfg_index == 1'(REG_BASE)) base_reg <= cfg_data;
            if (cfg_valid && cfg_index == 1'(REG_LIMIT)) limit_reg <= cfg_data[16:0];
            if (state_reg == S_DONE) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg  <= s_tdata[1:0];
            req_reg  <= s_tdata[18:2];
            addr_reg <= s_tdata[50:19];
        end
        ret_reg      <= ret_next;
        need_reg     <= need_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        g_reg        <= g_next;
        sz_reg       <= sz_next;
        rm_reg       <= rm_next;
        steps_reg    <= steps_next;
        ok_reg       <= ok_next;
        res_addr_reg <= res_addr_next;
        res_use_reg  <= res_use_next;
    end

    // free-list unlink of rm_reg: read prev/next (RMGO), then write (FRM2)
    always_comb begin
        logic [GW-1:0] gsz;
        logic [GW:0]   tsum;
        gsz = '0; tsum = '0;
        state_next = state_reg; ret_next = ret_reg;
        head_next = head_reg; top_next = top_reg;
        need_next = need_reg; cur_next = cur_reg; best_next = best_reg;
        g_next = g_reg; sz_next = sz_reg; rm_next = rm_reg; steps_next = steps_reg;
        ok_next = ok_reg;
        res_addr_next = res_addr_reg; res_use_next = res_use_reg;
        hd_we = 1'b0; ft_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        hd_wa = '0; ft_wa = '0; nx_wa = '0; pv_wa = '0;
        hd_wd = '0; ft_wd = '0; nx_wd = '0; pv_wd = '0;
        hd_ra = cur_reg[AW-1:0]; ft_ra = '0;
        nx_ra = cur_reg[AW-1:0]; pv_ra = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) state_next = S_DEC;
            end
            S_DEC: begin
                res_addr_next = '0; res_use_next = '0;
                ret_next = S_DONE;
                need_next = (need_raw < (GW+1)'(MING)) ? GW'(MING) : GW'(need_raw);
                cur_next = head_reg; best_next = NIL; steps_next = '0;
                g_next = GW'(off >> SH);
                ok_next = (off[SH-1:0] == '0) && ((off >> SH) < 32'(top_reg))
                          && (addr_reg != 32'd0);
                case (cmd_reg)
                    CMD_ALLOC: state_next = S_WREQ;
                    CMD_FREE:  state_next = S_FHDR;
                    CMD_QUERY: state_next = S_QHDR;
                    default:   state_next = S_DONE;
                endcase
            end
            // walk: read header and next of cur
            S_WREQ: begin
                if (cur_reg >= NIL || steps_reg >= NIL) state_next = S_APICK;
                else state_next = S_WCHK;
            end
            S_WCHK: begin
                if (hsz >= need_reg && cur_reg < best_reg) best_next = cur_reg;
                cur_next = nx_rd; steps_next = steps_reg + 1'b1;
                state_next = S_WREQ;
            end
            S_APICK: begin
                if (best_reg < NIL) begin
                    hd_ra = best_reg[AW-1:0];
                    state_next = S_ARD;
                end else if ((GW+1)'(top_reg) + (GW+1)'(need_reg) > (GW+1)'(cap)) begin
                    state_next = S_DONE;
                end else begin
                    best_next = top_reg;
                    top_next = top_reg + need_reg;
                    sz_next = need_reg;
                    state_next = S_ASPL2;
                end
            end
            S_ARD: begin
                sz_next = hsz;
                rm_next = best_reg; ret_next = S_ARM;
                state_next = S_RMGO;
            end
            S_ARM: begin
                if (sz_reg - need_reg >= GW'(MING)) state_next = S_ASPL;
                else state_next = S_ASPL2;
            end
            S_ASPL: begin
                // remainder chunk tags
                g_next = best_reg + need_reg;
                gsz = sz_reg - need_reg;
                hd_we = 1'b1; hd_wa = AW'(best_reg + need_reg); hd_wd = {gsz, 1'b0};
                ft_we = 1'b1; ft_wa = AW'(best_reg + sz_reg - 1'b1); ft_wd = {gsz, 1'b0};
                sz_next = need_reg;
                ret_next = S_APUSH;
                state_next = S_ASPL2;
            end
            S_ASPL2: begin
                hd_we = 1'b1; hd_wa = best_reg[AW-1:0]; hd_wd = {sz_reg, 1'b1};
                ft_we = 1'b1; ft_wa = AW'(best_reg + sz_reg - 1'b1); ft_wd = {sz_reg, 1'b1};
                res_addr_next = pay_best;
                state_next = (ret_reg == S_APUSH && best_reg != top_reg - sz_reg)
                             ? S_APUSH : S_DONE;
                if (ret_reg == S_APUSH) state_next = S_APUSH;
            end
            S_APUSH: begin
                // push g_reg at head
                nx_we = 1'b1; nx_wa = g_reg[AW-1:0]; nx_wd = head_reg;
                pv_we = 1'b1; pv_wa = g_reg[AW-1:0]; pv_wd = NIL;
                head_next = g_reg;
                state_next = S_FEND;
            end
            S_FEND: begin
                // fix prev of old head, stored in nx entry just written
                nx_ra = g_reg[AW-1:0];
                state_next = S_FLRD;
            end
            S_FLRD: begin
                if (nx_rd < NIL) begin
                    pv_we = 1'b1; pv_wa = nx_rd[AW-1:0]; pv_wd = g_reg;
                end
                state_next = S_DONE;
            end
            S_RMGO: begin
                nx_ra = rm_reg[AW-1:0]; pv_ra = rm_reg[AW-1:0];
                state_next = S_FRM2;
            end
            S_FRM2: begin
                if (pv_rd < NIL) begin
                    nx_we = 1'b1; nx_wa = pv_rd[AW-1:0]; nx_wd = nx_rd;
                end else begin
                    head_next = nx_rd;
                end
                if (nx_rd < NIL) begin
                    pv_we = 1'b1; pv_wa = nx_rd[AW-1:0]; pv_wd = pv_rd;
                end
                state_next = ret_reg;
                if (ret_reg == S_ARM) ret_next = S_DONE;
            end
            S_FHDR: begin
                hd_ra = g_reg[AW-1:0];
                state_next = ok_reg ? S_FCHK : S_DONE;
            end
            S_FCHK: begin
                tsum = (GW+1)'(g_reg) + (GW+1)'(hsz);
                sz_next = hsz;
                hd_ra = AW'(tsum);
                if (!hd_rd[0] || hsz == '0 || tsum > (GW+1)'(top_reg)) state_next = S_DONE;
                else if (tsum < (GW+1)'(top_reg)) state_next = S_FRGT;
                else state_next = S_FLFT;
            end
            S_FRGT: begin
                tsum = (GW+1)'(g_reg) + (GW+1)'(sz_reg) + (GW+1)'(hsz);
                state_next = S_FLFT;
                if (!hd_rd[0] && hsz != '0 && tsum <= (GW+1)'(top_reg)) begin
                    rm_next = g_reg + sz_reg;
                    sz_next = sz_reg + hsz;
                    ret_next = S_FLFT;
                    state_next = S_RMGO;
                end
            end
            S_FLFT: begin
                ft_ra = AW'(g_reg - 1'b1);
                state_next = (g_reg != '0) ? S_FLFT2 : S_FRMW;
            end
            S_FLFT2: begin
                gsz = ft_rd[TW-1:1];
                state_next = S_FRMW;
                if (!ft_rd[0] && gsz != '0 && gsz <= g_reg) begin
                    g_next = g_reg - gsz;
                    rm_next = g_reg - gsz;
                    sz_next = sz_reg + gsz;
                    ret_next = S_FRMW;
                    state_next = S_RMGO;
                end
            end
            S_FRMW: begin
                if (g_reg + sz_reg == top_reg) begin
                    top_next = g_reg;
                    state_next = S_DONE;
                end else begin
                    hd_we = 1'b1; hd_wa = g_reg[AW-1:0]; hd_wd = {sz_reg, 1'b0};
                    ft_we = 1'b1; ft_wa = AW'(g_reg + sz_reg - 1'b1); ft_wd = {sz_reg, 1'b0};
                    ret_next = S_APUSH;
                    state_next = S_APUSH;
                end
            end
            S_QHDR: begin
                hd_ra = g_reg[AW-1:0];
                state_next = ok_reg ? S_QOUT : S_DONE;
            end
            S_QOUT: begin
                if ((LW+1)'(hsz) << SH >= (LW+1)'(2 * HDR_BYTES))
                    res_use_next = 17'(((LW+1)'(hsz) << SH) - (LW+1)'(2 * HDR_BYTES));
                state_next = S_DONE;
            end
            S_DONE: begin
                ret_next = S_IDLE;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second item taken");
    a_top_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= NIL) else $error("top past heap");
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= NIL) else $error("head out of range");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif
endmodule

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffha_pkg::*;

    localparam int          GRAN      = 4096;
    localparam int          NIL_G     = 4096;
    localparam logic [1:0]  CMD_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [16:0] req;
        logic [31:0] addr;
    } heap_cmd_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [16:0] usable;
    } heap_rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    first_fit_heap_allocator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow heap state
    logic [13:0] hdr_tag [GRAN];
    logic [13:0] ftr_tag [GRAN];
    logic [12:0] nxt_link [GRAN];
    logic [12:0] prv_link [GRAN];
    int unsigned head_g;
    int unsigned top_g;
    logic [31:0] base_r;
    int unsigned limit_r;

    heap_cmd_t   cmd_q[$];
    heap_rsp_t   rsp_q[$];
    int          errors = 0;
    int          n_alloc = 0, n_oom = 0, n_free = 0, n_query = 0, n_other = 0, n_cfg = 0;

    function automatic int unsigned tag_gran(logic [13:0] t);
        return int'(t >> 1);
    endfunction

    function automatic void set_tags(int unsigned g, int unsigned sz, bit used);
        logic [13:0] t;
        t = 14'((sz << 1) | used);
        if (g < GRAN) hdr_tag[g] = t;
        if (sz > 0 && g + sz - 1 < GRAN) ftr_tag[g + sz - 1] = t;
    endfunction

    function automatic void unlink(int unsigned c);
        int unsigned p, n;
        p = (c < GRAN) ? prv_link[c] : NIL_G;
        n = (c < GRAN) ? nxt_link[c] : NIL_G;
        if (p < GRAN) nxt_link[p] = 13'(n);
        else head_g = n;
        if (n < GRAN) prv_link[n] = 13'(p);
    endfunction

    function automatic void link_front(int unsigned c);
        if (c >= GRAN) return;
        nxt_link[c] = 13'(head_g);
        prv_link[c] = 13'(NIL_G);
        if (head_g < GRAN) prv_link[head_g] = 13'(c);
        head_g = c;
    endfunction

    function automatic logic [31:0] base_al();
        return {base_r[31:4], 4'b0};
    endfunction

    function automatic logic [31:0] payload_at(int unsigned g);
        return base_al() + 32'(g * 16) + 32'd8;
    endfunction

    function automatic bit locate(logic [31:0] p, output int unsigned g);
        logic [31:0] off;
        off = p - base_al() - 32'd8;
        g = 0;
        if (off[3:0] != 4'd0) return 0;
        if ((off >> 4) >= top_g) return 0;
        g = int'(off >> 4);
        return 1;
    endfunction

    function automatic logic [31:0] heap_alloc(logic [16:0] req);
        longint unsigned n, need, bsz, rest, cap;
        int unsigned c, best, steps;
        n = (req == 0) ? 1 : req;
        need = (n + 31) / 16;
        if (need < 2) need = 2;
        c = head_g;
        best = NIL_G;
        steps = 0;
        while (c < GRAN && steps < GRAN) begin
            if (tag_gran(hdr_tag[c]) >= need && c < best) best = c;
            c = nxt_link[c];
            steps++;
        end
        if (best < GRAN) begin
            bsz = tag_gran(hdr_tag[best]);
            rest = bsz - need;
            unlink(best);
            if (rest >= 2) begin
                set_tags(best, int'(need), 1'b1);
                set_tags(best + int'(need), int'(rest), 1'b0);
                link_front(best + int'(need));
            end else begin
                set_tags(best, int'(bsz), 1'b1);
            end
            return payload_at(best);
        end
        cap = ((limit_r > 65536) ? 65536 : limit_r) / 16;
        if (top_g + need > cap) return 32'd0;
        c = top_g;
        top_g = top_g + int'(need);
        set_tags(c, int'(need), 1'b1);
        return payload_at(c);
    endfunction

    function automatic void heap_free(logic [31:0] p);
        int unsigned g, r, rs, ls, sz;
        logic [13:0] h, f;
        if (p == 0 || !locate(p, g)) return;
        h = hdr_tag[g];
        sz = tag_gran(h);
        if (!h[0] || sz == 0 || g + sz > top_g) return;
        r = g + sz;
        if (r < top_g) begin
            h = hdr_tag[r];
            rs = tag_gran(h);
            if (!h[0] && rs > 0 && r + rs <= top_g) begin
                unlink(r);
                sz += rs;
            end
        end
        if (g > 0) begin
            f = ftr_tag[g - 1];
            ls = tag_gran(f);
            if (!f[0] && ls > 0 && ls <= g) begin
                g -= ls;
                unlink(g);
                sz += ls;
            end
        end
        if (g + sz == top_g) begin
            top_g = g;
            return;
        end
        set_tags(g, sz, 1'b0);
        link_front(g);
    endfunction

    function automatic logic [16:0] heap_usable(logic [31:0] p);
        int unsigned g, bytes;
        if (p == 0 || !locate(p, g)) return 17'd0;
        bytes = tag_gran(hdr_tag[g]) * 16;
        if (bytes < 16) return 17'd0;
        return 17'(bytes - 16);
    endfunction

    function automatic heap_rsp_t issue(logic [1:0] cmd, logic [16:0] req, logic [31:0] addr);
        heap_rsp_t r;
        r = '0;
        case (cmd)
            CMD_ALLOC: begin
                r.addr = heap_alloc(req);
                n_alloc++;
                if (r.addr == 0) n_oom++;
            end
            CMD_FREE: begin
                heap_free(addr);
                n_free++;
            end
            CMD_QUERY: begin
                r.usable = heap_usable(addr);
                n_query++;
            end
            default: n_other++;
        endcase
        cmd_q.push_back('{cmd: cmd, req: req, addr: addr});
        rsp_q.push_back(r);
        return r;
    endfunction

    // chunk starts in address order, tiling [0, top)
    function automatic void list_chunks(ref int unsigned used_g[$], ref int unsigned all_g[$]);
        int unsigned g;
        used_g.delete();
        all_g.delete();
        g = 0;
        while (g < top_g) begin
            all_g.push_back(g);
            if (hdr_tag[g][0]) used_g.push_back(g);
            g += tag_gran(hdr_tag[g]);
        end
    endfunction

    function automatic logic [16:0] pick_size();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 70) return 17'($urandom_range(0, 64));
        if (k < 95) return 17'($urandom_range(65, 1024));
        if (k < 98) return 17'($urandom_range(0, 65536));
        return 17'd65536;
    endfunction

    function automatic void random_item();
        int unsigned used_g[$], all_g[$];
        int unsigned r, k, g;
        logic [31:0] a;
        logic [16:0] junk;
        heap_rsp_t   d;
        list_chunks(used_g, all_g);
        r = $urandom_range(0, 99);
        junk = 17'($urandom_range(0, 65536));
        if (r < 45) begin
            d = issue(CMD_ALLOC, pick_size(), $urandom());
        end else if (r < 80 && used_g.size() > 0) begin
            d = issue(CMD_FREE, junk, payload_at(used_g[$urandom_range(0, used_g.size() - 1)]));
        end else if (r < 88 && all_g.size() > 0) begin
            d = issue(CMD_QUERY, junk, payload_at(all_g[$urandom_range(0, all_g.size() - 1)]));
        end else begin
            k = $urandom_range(0, 6);
            case (k)
                0: d = issue(CMD_FREE, junk, 32'd0);
                1: d = issue(CMD_QUERY, junk, 32'd0);
                2: d = issue(CMD_NONE, junk, $urandom());
                3: begin
                    g = (all_g.size() > 0) ? all_g[$urandom_range(0, all_g.size() - 1)] : 0;
                    a = payload_at(g) + 32'($urandom_range(1, 15));
                    d = issue($urandom_range(0, 1) ? CMD_FREE : CMD_QUERY, junk, a);
                end
                4: begin
                    // free of a chunk that is already free, or of the first chunk
                    a = payload_at(0);
                    foreach (all_g[i]) if (!hdr_tag[all_g[i]][0]) a = payload_at(all_g[i]);
                    d = issue(CMD_FREE, junk, a);
                end
                5: d = issue($urandom_range(0, 1) ? CMD_FREE : CMD_QUERY, junk,
                             payload_at(top_g + $urandom_range(0, 100)));
                default: begin
                    a = $urandom();
                    // a hit inside the heap must land on a chunk start
                    if (locate(a, g)) begin
                        if (!(g inside {all_g})) a = 32'd0;
                    end
                    d = issue($urandom_range(0, 1) ? CMD_FREE : CMD_QUERY, junk, a);
                end
            endcase
        end
    endfunction

    // handshake flags, sampled before the edge updates the block
    logic s_fire = 1'b0;
    logic cfg_fire = 1'b0;
    heap_rsp_t mon_exp;
    heap_rsp_t mon_got;

    always @(posedge aclk) begin
        s_fire   <= s_tvalid && s_tready;
        cfg_fire <= cfg_valid && cfg_ready;
        if (aresetn && m_tvalid && m_tready) begin
            mon_got.addr   = m_tdata[31:0];
            mon_got.usable = m_tdata[48:32];
            if (rsp_q.size() == 0) begin
                $error("result beat with nothing pending: addr %h usable %0d",
                       mon_got.addr, mon_got.usable);
                errors++;
            end else begin
                mon_exp = rsp_q.pop_front();
                if (mon_got.addr !== mon_exp.addr) begin
                    $error("result_address: expected %h, got %h", mon_exp.addr, mon_got.addr);
                    errors++;
                end
                if (mon_got.usable !== mon_exp.usable) begin
                    $error("usable_bytes: expected %0d, got %0d",
                           mon_exp.usable, mon_got.usable);
                    errors++;
                end
            end
        end
    end

    // sender: bursts with gaps
    int        burst_left = 0;
    int        gap_left = 0;
    heap_cmd_t drv_item;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                drv_item = cmd_q.pop_front();
                s_tdata  <= {5'b0, drv_item.addr, drv_item.req, drv_item.cmd};
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall rate changes every stretch
    int rdy_pct = 100;
    int rdy_cnt = 0;

    always @(negedge aclk) begin
        if (rdy_cnt == 0) begin
            rdy_cnt = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: rdy_pct = 100;
                1: rdy_pct = 75;
                2: rdy_pct = 40;
                default: rdy_pct = 10;
            endcase
        end
        rdy_cnt--;
        m_tready <= ($urandom_range(0, 99) < rdy_pct);
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_fire) @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == 1'(REG_BASE)) base_r = val;
        else limit_r = int'(val[16:0]);
        n_cfg++;
    endtask

    task automatic drain();
        while (rsp_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    initial begin
        #100ms;
        $display("[first_fit_heap_allocator_top] ERROR");
        $finish;
    end

    initial begin
        heap_rsp_t a0, a1, a2, a3, a4, d;
        logic [31:0] bases [5];
        int unsigned limits [5];
        head_g  = NIL_G;
        top_g   = 0;
        base_r  = 32'd0;
        limit_r = 65536;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        write_reg(1'(REG_BASE), 32'd0);
        write_reg(1'(REG_LIMIT), 32'd65536);

        // directed: sizing edges, coalescing, top return, invalid addresses
        a0 = issue(CMD_ALLOC, 17'd0, 32'd0);
        a1 = issue(CMD_ALLOC, 17'd16, 32'd0);
        a2 = issue(CMD_ALLOC, 17'd17, 32'hFFFF_FFFF);
        a3 = issue(CMD_ALLOC, 17'd100, 32'd0);
        a4 = issue(CMD_ALLOC, 17'd1, 32'd0);
        d = issue(CMD_QUERY, 17'd0, a0.addr);
        d = issue(CMD_QUERY, 17'd0, a2.addr);
        d = issue(CMD_QUERY, 17'd0, 32'd0);
        d = issue(CMD_FREE, 17'h1FFFF & 17'd65536, 32'd0);
        d = issue(CMD_FREE, 17'd0, a1.addr);
        d = issue(CMD_FREE, 17'd0, a1.addr);
        d = issue(CMD_FREE, 17'd0, a2.addr);
        d = issue(CMD_QUERY, 17'd0, a1.addr);
        d = issue(CMD_ALLOC, 17'd20, 32'd0);
        d = issue(CMD_FREE, 17'd0, a4.addr);
        d = issue(CMD_QUERY, 17'd0, a0.addr + 32'd4);
        d = issue(CMD_QUERY, 17'd0, payload_at(top_g));
        d = issue(CMD_FREE, 17'd0, a3.addr + 32'd8);
        d = issue(CMD_NONE, 17'd65536, 32'hFFFF_FFFF);
        d = issue(CMD_ALLOC, 17'd65536, 32'd0);
        d = issue(CMD_ALLOC, 17'd65535, 32'd0);
        d = issue(CMD_FREE, 17'd0, a3.addr);
        d = issue(CMD_FREE, 17'd0, a0.addr);
        drain();

        bases[0]  = 32'h0001_2347;  limits[0] = 65536;
        bases[1]  = 32'hFFFF_FF00;  limits[1] = 2048;
        bases[2]  = $urandom();     limits[2] = 0;
        bases[3]  = 32'hFFFF_FFF0;  limits[3] = 131071;
        bases[4]  = 32'd0;          limits[4] = $urandom_range(512, 65536);
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(1'(REG_BASE), bases[ph]);
            write_reg(1'(REG_LIMIT), 32'(limits[ph]));
            for (int i = 0; i < 150; i++) random_item();
            drain();
        end

        $display("covered %0d allocs (%0d out of memory), %0d frees, %0d queries, %0d unknown",
                 n_alloc, n_oom, n_free, n_query, n_other);
        $display("over %0d register writes, base wrap and limit 0..capped", n_cfg);
        if (errors == 0) begin
            $display("[first_fit_heap_allocator_top] OK");
        end else begin
            $display("[first_fit_heap_allocator_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
